@@ design/dvcm_pkg.sv @@
// shared types and constants for the diverging value colour map
// no dependencies
package dvcm_pkg;

    localparam int DEF_VALUE_BITS   = 32;
    localparam int DEF_CHANNEL_BITS = 8;
    localparam int CFG_INDEX_BITS   = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NEG_LIMIT = 1'b0,
        REG_POS_LIMIT = 1'b1
    } t_reg_index;

    // sideband that travels with an item down the divider chain
    typedef struct packed {
        logic neg;          // sample was negative
        logic force_s;      // ratio is settled without dividing
        logic force_full;   // settled ratio is full scale, else zero
    } t_side;

endpackage

@@ design/dvcm_prep.sv @@
// front end: limit select, magnitudes, special cases and the scaled dividend
// depends on dvcm_pkg
module dvcm_prep import dvcm_pkg::*; #(
    parameter int VALUE_BITS   = DEF_VALUE_BITS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    localparam int QB          = CHANNEL_BITS + 2,
    localparam int PW          = VALUE_BITS + CHANNEL_BITS + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [VALUE_BITS-1:0] i_neg_limit,
    input  logic signed [VALUE_BITS-1:0] i_pos_limit,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VALUE_BITS-1:0] i_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output t_side                        o_side,
    output logic [VALUE_BITS-1:0]        o_rem,
    output logic [VALUE_BITS-1:0]        o_div,
    output logic [QB-1:0]                o_low
);

    // stage a: magnitudes and sign checks
    logic                  r_va;
    logic                  r_neg;
    logic                  r_zero_lim;
    logic                  r_clear;
    logic [VALUE_BITS-1:0] r_nv;
    logic [VALUE_BITS-1:0] r_nl;
    logic                  ready_a;

    // stage b: compare and scaled dividend
    logic                  r_vb;
    t_side                 r_side;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_div;
    logic [QB-1:0]         r_low;
    logic                  ready_b;

    logic [VALUE_BITS-1:0] sample_u;
    logic [VALUE_BITS-1:0] lim_u;
    logic                  sample_neg;
    logic                  ge;
    logic [PW-1:0]         prod;
    t_side                 n_side;

    assign ready_b = !r_vb || i_ready;
    assign ready_a = !r_va || ready_b;
    assign o_ready = ready_a;

    always_comb begin
        sample_u   = i_sample;
        sample_neg = sample_u[VALUE_BITS-1];
        lim_u      = sample_neg ? i_neg_limit : i_pos_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (ready_a) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_neg      <= sample_neg;
            r_zero_lim <= (lim_u == '0);
            r_clear    <= (sample_u == '0) || (sample_neg != lim_u[VALUE_BITS-1]);
            r_nv       <= sample_neg ? (~sample_u + 1'b1) : sample_u;
            r_nl       <= lim_u[VALUE_BITS-1] ? (~lim_u + 1'b1) : lim_u;
        end
    end

    // times 4*(2^CHANNEL_BITS - 1), done as two shifts and a subtract
    always_comb begin
        ge   = (r_nv >= r_nl);
        prod = (PW'(r_nv) << (CHANNEL_BITS + 2)) - (PW'(r_nv) << 2);
        n_side.neg        = r_neg;
        n_side.force_s    = r_zero_lim || r_clear || ge;
        n_side.force_full = r_zero_lim || (!r_clear && ge);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (ready_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && r_va) begin
            r_side <= n_side;
            r_rem  <= prod[PW-1:QB];
            r_low  <= prod[QB-1:0];
            r_div  <= r_nl;
        end
    end

    assign o_valid = r_vb;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_low   = r_low;

endmodule

@@ design/dvcm_div_cell.sv @@
// one restoring division step: brings down a dividend bit, yields a quotient bit
// depends on dvcm_pkg
module dvcm_div_cell import dvcm_pkg::*; #(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int QB         = DEF_CHANNEL_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_side                 i_side,
    input  logic [VALUE_BITS-1:0] i_rem,
    input  logic [VALUE_BITS-1:0] i_div,
    input  logic [QB-1:0]         i_low,
    input  logic [QB-1:0]         i_quot,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_side                 o_side,
    output logic [VALUE_BITS-1:0] o_rem,
    output logic [VALUE_BITS-1:0] o_div,
    output logic [QB-1:0]         o_low,
    output logic [QB-1:0]         o_quot
);

    logic                  r_valid;
    t_side                 r_side;
    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_div;
    logic [QB-1:0]         r_low;
    logic [QB-1:0]         r_quot;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic                  qbit;
    logic [VALUE_BITS-1:0] n_rem;
    logic                  up_ready;

    assign up_ready = !r_valid || i_ready;
    assign o_ready  = up_ready;

    // remainder stays below the divisor, so the result fits back in VALUE_BITS
    always_comb begin
        trial = {i_rem, i_low[QB-1]};
        diff  = trial - {1'b0, i_div};
        qbit  = (trial >= {1'b0, i_div});
        n_rem = qbit ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (up_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (up_ready && i_valid) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_low  <= {i_low[QB-2:0], 1'b0};
            r_quot <= {i_quot[QB-2:0], qbit};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_low   = r_low;
    assign o_quot  = r_quot;

endmodule

@@ design/dvcm_color.sv @@
// rounding of the ratio and hue sector mapping into the output register
// depends on dvcm_pkg
module dvcm_color import dvcm_pkg::*; #(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    localparam int QB          = CHANNEL_BITS + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_side                   i_side,
    input  logic [QB-1:0]           i_quot,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CHANNEL_BITS-1:0] o_red,
    output logic [CHANNEL_BITS-1:0] o_green,
    output logic [CHANNEL_BITS-1:0] o_blue
);

    localparam logic [CHANNEL_BITS:0] CMAX   = {1'b0, {CHANNEL_BITS{1'b1}}};
    localparam logic [CHANNEL_BITS:0] KSCALE = {{CHANNEL_BITS{1'b1}}, 1'b0};

    logic                    r_valid;
    logic [CHANNEL_BITS-1:0] r_red;
    logic [CHANNEL_BITS-1:0] r_green;
    logic [CHANNEL_BITS-1:0] r_blue;

    logic [QB:0]             quot_inc;
    logic [CHANNEL_BITS:0]   s;
    logic [CHANNEL_BITS:0]   s_rest;
    logic [CHANNEL_BITS-1:0] n_red;
    logic [CHANNEL_BITS-1:0] n_green;
    logic [CHANNEL_BITS-1:0] n_blue;
    logic                    up_ready;

    assign up_ready = !r_valid || i_ready;
    assign o_ready  = up_ready;

    // quotient carries one extra fraction bit: add one and halve to round half up
    always_comb begin
        quot_inc = {1'b0, i_quot} + 1'b1;
        if (i_side.force_s) begin
            s = i_side.force_full ? KSCALE : '0;
        end else begin
            s = quot_inc[CHANNEL_BITS+1:1];
        end
        s_rest = KSCALE - s;
        if (!i_side.neg) begin
            n_blue = '0;
            if (s >= CMAX) begin
                n_red   = CMAX[CHANNEL_BITS-1:0];
                n_green = s_rest[CHANNEL_BITS-1:0];
            end else begin
                n_red   = s[CHANNEL_BITS-1:0];
                n_green = CMAX[CHANNEL_BITS-1:0];
            end
        end else begin
            n_red = '0;
            if (s <= CMAX) begin
                n_green = CMAX[CHANNEL_BITS-1:0];
                n_blue  = s[CHANNEL_BITS-1:0];
            end else begin
                n_green = s_rest[CHANNEL_BITS-1:0];
                n_blue  = CMAX[CHANNEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (up_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (up_ready && i_valid) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

@@ design/diverging_value_color_map.sv @@
// top level of the diverging value colour map: limit registers, front end,
// divider cell chain and colour stage; depends on dvcm_pkg and all dvcm_ modules
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_ready   i_sample_value
//  out       source     o_out_valid / i_out_ready o_red, o_green, o_blue
//  cfg       sink       i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// one item per cycle while the output is not stalled; two front-end stages,
// one divider cell per quotient bit (CHANNEL_BITS + 2 cells), one output stage
// every stage holds its own item, so bubbles close up while the output stalls
// synchronous active-low reset empties the chain and clears both limits to zero
module diverging_value_color_map import dvcm_pkg::*; #(
    parameter int VALUE_BITS   = DEF_VALUE_BITS,
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic signed [VALUE_BITS-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [VALUE_BITS-1:0]  i_sample_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [CHANNEL_BITS-1:0]       o_red,
    output logic [CHANNEL_BITS-1:0]       o_green,
    output logic [CHANNEL_BITS-1:0]       o_blue
);

    localparam int QB = CHANNEL_BITS + 2;
    localparam logic [CHANNEL_BITS-1:0] CMAX = {CHANNEL_BITS{1'b1}};

    logic signed [VALUE_BITS-1:0] r_neg_limit;
    logic signed [VALUE_BITS-1:0] r_pos_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg_limit <= '0;
            r_pos_limit <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_NEG_LIMIT: r_neg_limit <= i_cfg_data;
                REG_POS_LIMIT: r_pos_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // links between the cells, element k feeds cell k
    logic                  c_valid [0:QB];
    logic                  c_ready [0:QB];
    t_side                 c_side  [0:QB];
    logic [VALUE_BITS-1:0] c_rem   [0:QB];
    logic [VALUE_BITS-1:0] c_div   [0:QB];
    logic [QB-1:0]         c_low   [0:QB];
    logic [QB-1:0]         c_quot  [0:QB];

    dvcm_prep #(
        .VALUE_BITS   (VALUE_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_neg_limit (r_neg_limit),
        .i_pos_limit (r_pos_limit),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_sample    (i_sample_value),
        .o_valid     (c_valid[0]),
        .i_ready     (c_ready[0]),
        .o_side      (c_side[0]),
        .o_rem       (c_rem[0]),
        .o_div       (c_div[0]),
        .o_low       (c_low[0])
    );

    assign c_quot[0] = '0;

    for (genvar k = 0; k < QB; k++) begin : g_cell
        dvcm_div_cell #(
            .VALUE_BITS (VALUE_BITS),
            .QB         (QB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_side  (c_side[k]),
            .i_rem   (c_rem[k]),
            .i_div   (c_div[k]),
            .i_low   (c_low[k]),
            .i_quot  (c_quot[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_side  (c_side[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_div   (c_div[k+1]),
            .o_low   (c_low[k+1]),
            .o_quot  (c_quot[k+1])
        );
    end

    dvcm_color #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[QB]),
        .o_ready (c_ready[QB]),
        .i_side  (c_side[QB]),
        .i_quot  (c_quot[QB]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

`ifndef ASSERT_OFF
    // red and blue sit on opposite halves of the map
    a_red_blue_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red == '0 || o_blue == '0))
        else $error("red and blue both lit");

    // full saturation and value: some channel is always at full scale
    a_one_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red == CMAX || o_green == CMAX || o_blue == CMAX))
        else $error("no channel at full scale");

    // reset empties the chain
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("item left after reset");
`endif

endmodule

@@ verif/diverging_value_color_map_tb.sv @@
// self-checking testbench for the diverging value colour map
// drives samples and limit writes, predicts each rgb item or takes it from the table and checks it in order
// depends on dvcm_pkg and diverging_value_color_map
`timescale 1ns / 100ps

module diverging_value_color_map_tb;
    import dvcm_pkg::*;

    localparam int VW        = DEF_VALUE_BITS;
    localparam int CW        = DEF_CHANNEL_BITS;
    localparam int CH_FULL   = (1 << CW) - 1;
    localparam int SPAN      = 2 * CH_FULL;
    localparam int LATENCY   = CW + 5;
    localparam int PHASES    = 8;
    localparam int PHASE_LEN = 190;
    localparam int HOLD_AT   = 500;
    localparam int HOLD_LEN  = 80;
    localparam int ROWS      = 24;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
    } t_colour;

    typedef struct packed {
        logic [VW-1:0] neg_lim;
        logic [VW-1:0] pos_lim;
        logic [VW-1:0] sample;
        logic          known;
        t_colour       colour;
    } t_row;

    // limits in q16.16; colour typed in only where it is obvious
    localparam t_row DIRECTED_ROWS [0:ROWS-1] = '{
        '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{32'h00000000, 32'h00000000, 32'h7fffffff, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{32'h00000000, 32'h00000000, 32'hffffffff, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{32'h00000000, 32'h00000000, 32'h80000000, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{32'hffff0000, 32'h00010000, 32'h00000000, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{32'hffff0000, 32'h00010000, 32'h00010000, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{32'hffff0000, 32'h00010000, 32'hffff0000, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{32'hffff0000, 32'h00010000, 32'h00008000, 1'b1, '{8'd255, 8'd255, 8'd0}},
        '{32'hffff0000, 32'h00010000, 32'hffff8000, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{32'hffff0000, 32'h00010000, 32'h7fffffff, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{32'hffff0000, 32'h00010000, 32'h80000000, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{32'hffff0000, 32'h00010000, 32'h00000001, 1'b0, '0},
        '{32'hffff0000, 32'h00010000, 32'hffffffff, 1'b0, '0},
        '{32'hffff0000, 32'h00010000, 32'h0000ffff, 1'b0, '0},
        // limits of the wrong sign give pure green; then the full-range limits
        '{32'h00010000, 32'hffff0000, 32'h00000064, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{32'h00010000, 32'hffff0000, 32'hffffff9c, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{32'h80000000, 32'h7fffffff, 32'h80000001, 1'b0, '0},
        '{32'h80000000, 32'h7fffffff, 32'hc0000000, 1'b0, '0},
        '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{32'h80000000, 32'h7fffffff, 32'h3fffffff, 1'b0, '0},
        // exact rounding midpoints, then a sample at exactly half the limit
        '{32'hfffffc04, 32'h000003fc, 32'h00000001, 1'b0, '0},
        '{32'hfffffc04, 32'h000003fc, 32'hffffffff, 1'b0, '0},
        '{32'hfffffc04, 32'h000003fc, 32'h000001fe, 1'b0, '0}
    };

    logic          i_clk;
    logic          i_rst_n        = 1'b0;
    logic          i_cfg_we       = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [VW-1:0] i_cfg_data     = '0;
    logic          i_in_valid     = 1'b0;
    logic          o_in_ready;
    logic [VW-1:0] i_sample_value = '0;
    logic          o_out_valid;
    logic          i_out_ready    = 1'b0;
    logic [CW-1:0] o_red;
    logic [CW-1:0] o_green;
    logic [CW-1:0] o_blue;

    logic [VW-1:0] neg_limit_model = '0;
    logic [VW-1:0] pos_limit_model = '0;
    t_colour       pending_colours [$];
    int unsigned   accepted_cnt   = 0;
    int unsigned   checked_cnt    = 0;
    int unsigned   mismatch_cnt   = 0;
    int unsigned   setting_cnt    = 0;
    bit            burst_mode     = 1'b0;
    bit            out_hold       = 1'b0;

    diverging_value_color_map u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("diverging_value_color_map_tb NOT OK");
        $finish;
    end

    function automatic logic [63:0] magnitude_of(logic [VW-1:0] v);
        if (v[VW-1])
            return 64'd0 - {{(64-VW){1'b1}}, v};
        return {{(64-VW){1'b0}}, v};
    endfunction

    function automatic t_colour predict_colour(logic [VW-1:0] sample);
        logic          neg;
        logic [VW-1:0] lim;
        logic [63:0]   mag_s;
        logic [63:0]   mag_l;
        logic [63:0]   level;
        t_colour       c;
        neg   = sample[VW-1];
        lim   = neg ? neg_limit_model : pos_limit_model;
        mag_s = magnitude_of(sample);
        mag_l = magnitude_of(lim);
        if (lim == '0)
            level = 64'(SPAN);
        else if (sample == '0 || neg != lim[VW-1])
            level = '0;
        else if (mag_s >= mag_l)
            level = 64'(SPAN);
        else
            level = (2 * SPAN * mag_s + mag_l) / (2 * mag_l);   // round half up
        if (!neg) begin
            c.blue = '0;
            if (level >= CH_FULL) begin
                c.red   = CW'(CH_FULL);
                c.green = CW'(SPAN - level);
            end else begin
                c.red   = CW'(level);
                c.green = CW'(CH_FULL);
            end
        end else begin
            c.red = '0;
            if (level <= CH_FULL) begin
                c.green = CW'(CH_FULL);
                c.blue  = CW'(level);
            end else begin
                c.green = CW'(SPAN - level);
                c.blue  = CW'(CH_FULL);
            end
        end
        return c;
    endfunction

    // mostly short, now and then long
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(20, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [VW-1:0] pick_limit_mag();
        return $urandom() >> $urandom_range(0, 31);
    endfunction

    // samples cluster inside the current limits so the whole ramp gets exercised
    function automatic logic [VW-1:0] pick_sample();
        logic          want_neg;
        logic [VW-1:0] lim;
        logic [63:0]   span;
        logic [63:0]   mag;
        want_neg = 1'($urandom_range(0, 1));
        lim      = want_neg ? neg_limit_model : pos_limit_model;
        span     = magnitude_of(lim);
        case ($urandom_range(0, 9))
            0: return $urandom();
            6: mag = 64'($urandom_range(0, 3));
            7: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return 32'h00000001;
                    2: return '1;
                    3: return 32'h7fffffff;
                    default: return 32'h80000000;
                endcase
            end
            8: mag = span * $urandom_range(0, 2 * SPAN) / (2 * SPAN);
            9: mag = 64'($urandom() >> $urandom_range(0, 31));
            default: begin
                if (span == 0)
                    mag = 64'($urandom_range(0, 255));
                else
                    mag = 64'($urandom_range(0, span[31:0])) + 64'($urandom_range(0, 1));
            end
        endcase
        return want_neg ? VW'(64'd0 - mag) : VW'(mag);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // leaves valid high at the accepting edge; the caller decides on a gap
    task automatic send_sample(input logic [VW-1:0] sample, input logic known,
                               input t_colour colour);
        i_in_valid     <= 1'b1;
        i_sample_value <= sample;
        do @(posedge i_clk); while (!o_in_ready);
        pending_colours.push_back(known ? colour : predict_colour(sample));
        accepted_cnt++;
    endtask

    task automatic sender_gap();
        int unsigned gap;
        gap = (!burst_mode && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_colours.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_limits(input logic [VW-1:0] neg_lim, input logic [VW-1:0] pos_lim);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_NEG_LIMIT;
        i_cfg_data  <= neg_lim;
        @(posedge i_clk);
        neg_limit_model = neg_lim;
        i_cfg_index <= REG_POS_LIMIT;
        i_cfg_data  <= pos_lim;
        @(posedge i_clk);
        pos_limit_model = pos_lim;
        i_cfg_we <= 1'b0;
        setting_cnt++;
    endtask

    // output side: random stalls, none in burst phases, plus the long hold
    initial begin : out_ready_gen
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0)
                stall_left--;
            else if (!burst_mode && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            i_out_ready <= !out_hold && stall_left == 0;
        end
    end

    // one long hold-off so the chain fills up and backs up the input
    initial begin : out_hold_gen
        wait (accepted_cnt >= HOLD_AT);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    initial begin : result_check
        t_colour got;
        t_colour want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = '{o_red, o_green, o_blue};
                if (pending_colours.size() == 0) begin
                    flag_mismatch($sformatf("colour item %0h with nothing expected", got));
                end else begin
                    want = pending_colours.pop_front();
                    checked_cnt++;
                    if (got.red != want.red)
                        flag_mismatch($sformatf("red %0d, want %0d", got.red, want.red));
                    if (got.green != want.green)
                        flag_mismatch($sformatf("green %0d, want %0d", got.green, want.green));
                    if (got.blue != want.blue)
                        flag_mismatch($sformatf("blue %0d, want %0d", got.blue, want.blue));
                end
            end
        end
    end

    initial begin : stimulus
        t_row          row;
        logic [VW-1:0] neg_lim;
        logic [VW-1:0] pos_lim;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            if (row.neg_lim != neg_limit_model || row.pos_lim != pos_limit_model) begin
                wait_idle();
                load_limits(row.neg_lim, row.pos_lim);
            end
            send_sample(row.sample, row.known, row.colour);
            sender_gap();
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    neg_lim = '0;
                    pos_lim = '0;
                end
                1: begin
                    neg_lim = 32'h80000000;
                    pos_lim = 32'h7fffffff;
                end
                2: begin
                    neg_lim = '1;
                    pos_lim = 32'h00000001;
                end
                6: begin
                    neg_lim = $urandom();
                    pos_lim = $urandom();
                end
                default: begin
                    neg_lim = VW'(0) - pick_limit_mag();
                    pos_lim = pick_limit_mag();
                end
            endcase
            wait_idle();
            load_limits(neg_lim, pos_lim);
            burst_mode = (phase == 2 || phase == 5);
            repeat (PHASE_LEN) begin
                send_sample(pick_sample(), 1'b0, '0);
                sender_gap();
            end
        end

        wait_idle();
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("covered %0d samples under %0d limit settings, %0d colours compared",
                 accepted_cnt, setting_cnt, checked_cnt);
        $display("output held off once for %0d cycles, %0d mismatches",
                 HOLD_LEN, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("diverging_value_color_map_tb OK");
        else
            $display("diverging_value_color_map_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
design/dvcm_pkg.sv
design/dvcm_prep.sv
design/dvcm_div_cell.sv
design/dvcm_color.sv
design/diverging_value_color_map.sv
verif/diverging_value_color_map_tb.sv
